// ----- sv/fdmd_pkg.sv -----
// ----------------------------------------------------------------------------
// fdmd_pkg
// Shared constants, register indexes, types and helpers for the frame
// difference motion detector.
// ----------------------------------------------------------------------------
package fdmd_pkg;

  // Default store geometry
  localparam int unsigned FDMD_MAX_COLUMNS = 320;
  localparam int unsigned FDMD_MAX_ROWS    = 240;

  // Field and register widths
  localparam int unsigned PIX_W       = 8;
  localparam int unsigned SKIP_W      = 4;
  localparam int unsigned PHASE_W     = 4;
  localparam int unsigned COLS_W      = 9;
  localparam int unsigned ROWS_W      = 8;
  localparam int unsigned GAIN_W      = 12;
  localparam int unsigned OFFS_W      = 8;
  localparam int unsigned COUNT_W     = 17;
  localparam int unsigned CFG_DATA_W  = 17;
  localparam int unsigned CFG_INDEX_W = 3;
  // Compare width for geometry limits (covers sizes up to 8191)
  localparam int unsigned DIM_W       = 13;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_HSKIP     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_VSKIP     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLUMNS   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROWS      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAIN      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 3'd6;

  // Register reset values
  localparam logic [SKIP_W-1:0]  RST_HSKIP     = 4'd2;
  localparam logic [SKIP_W-1:0]  RST_VSKIP     = 4'd2;
  localparam logic [COLS_W-1:0]  RST_COLUMNS   = 9'd160;
  localparam logic [ROWS_W-1:0]  RST_ROWS      = 8'd120;
  localparam logic [GAIN_W-1:0]  RST_GAIN      = 12'd26;
  localparam logic [OFFS_W-1:0]  RST_OFFSET    = 8'd10;
  localparam logic [COUNT_W-1:0] RST_THRESHOLD = 17'd96;

  // Decimation geometry used by the front
  typedef struct packed {
    logic [SKIP_W-1:0] hskip;
    logic [SKIP_W-1:0] vskip;
    logic [COLS_W-1:0] cols;
    logic [ROWS_W-1:0] rows;
  } fdmd_geom_t;

  // Change test settings used by the back
  typedef struct packed {
    logic [GAIN_W-1:0]  gain;
    logic [OFFS_W-1:0]  offset;
    logic [COUNT_W-1:0] threshold;
  } fdmd_test_t;

  // Classification of one queued request
  typedef struct packed {
    logic kept;
    logic frame_end;
  } fdmd_tag_t;

  // Back status seen at the top level
  typedef struct packed {
    logic s1_stalled;
    logic ram_read;
  } fdmd_back_status_t;

  // Advance a skip phase; a skip of zero acts as one
  function automatic logic [PHASE_W-1:0] next_phase(input logic [PHASE_W-1:0] phase,
                                                    input logic [SKIP_W-1:0]  skip);
    logic [PHASE_W:0]   inc;
    logic [PHASE_W-1:0] eff;
    eff = (skip == '0) ? PHASE_W'(1) : PHASE_W'(skip);
    inc = {1'b0, phase} + (PHASE_W+1)'(1);
    return (inc >= {1'b0, eff}) ? '0 : inc[PHASE_W-1:0];
  endfunction

endpackage

// ----- sv/fdmd_ram.sv -----
// ----------------------------------------------------------------------------
// fdmd_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// Read data holds while no read is issued; a read of the address being
// written returns the old contents.
// ----------------------------------------------------------------------------
module fdmd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/fdmd_front.sv -----
// ----------------------------------------------------------------------------
// fdmd_front
// Raster tracker: accepts pixels, applies decimation and size limits, and
// queues kept pixels and frame ends with their store address.
// ----------------------------------------------------------------------------
module fdmd_front #(
  parameter int unsigned MAX_COLUMNS = fdmd_pkg::FDMD_MAX_COLUMNS,
  parameter int unsigned MAX_ROWS    = fdmd_pkg::FDMD_MAX_ROWS
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic [fdmd_pkg::PIX_W-1:0]                in_pixel,
  input  logic                                      in_line_end,
  input  logic                                      in_frame_end,
  input  fdmd_pkg::fdmd_geom_t                      geom,
  input  logic                                      q_full,
  output logic                                      q_push,
  output fdmd_pkg::fdmd_tag_t                       q_tag,
  output logic [$clog2(MAX_COLUMNS*MAX_ROWS)-1:0]   q_addr,
  output logic [fdmd_pkg::PIX_W-1:0]                q_pixel
);

  import fdmd_pkg::*;

  localparam int unsigned DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned BW    = $clog2(DEPTH + 1);
  localparam int unsigned KCW   = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned KRW   = $clog2(MAX_ROWS + 1);

  logic [PHASE_W-1:0] raw_col_r, raw_col_nxt;
  logic [PHASE_W-1:0] raw_row_r, raw_row_nxt;
  logic [KCW-1:0]     kept_col_r, kept_col_nxt;
  logic [KRW-1:0]     kept_row_r, kept_row_nxt;
  logic [BW-1:0]      row_base_r, row_base_nxt;

  logic accept;
  logic row_kept;
  logic col_ok;
  logic kept;
  logic [BW-1:0] addr_sum;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Classification of the current pixel
  assign row_kept = (raw_row_r == '0)
                 && (DIM_W'(kept_row_r) < DIM_W'(geom.rows))
                 && (DIM_W'(kept_row_r) < DIM_W'(MAX_ROWS));
  assign col_ok   = (DIM_W'(kept_col_r) < DIM_W'(geom.cols))
                 && (DIM_W'(kept_col_r) < DIM_W'(MAX_COLUMNS));
  assign kept     = row_kept && (raw_col_r == '0) && col_ok;

  // Store address: row base plus kept column
  assign addr_sum = row_base_r + BW'(kept_col_r);

  assign q_push          = accept && (kept || in_frame_end);
  assign q_tag.kept      = kept;
  assign q_tag.frame_end = in_frame_end;
  assign q_addr          = AW'(addr_sum);
  assign q_pixel         = in_pixel;

  // Raster counters
  always_comb begin
    raw_col_nxt  = raw_col_r;
    raw_row_nxt  = raw_row_r;
    kept_col_nxt = kept_col_r;
    kept_row_nxt = kept_row_r;
    row_base_nxt = row_base_r;
    if (accept) begin
      if (kept) begin
        kept_col_nxt = kept_col_r + KCW'(1);
      end
      raw_col_nxt = next_phase(raw_col_r, geom.hskip);
      if (in_line_end || in_frame_end) begin
        if (row_kept) begin
          kept_row_nxt = kept_row_r + KRW'(1);
          row_base_nxt = row_base_r + BW'(MAX_COLUMNS);
        end
        raw_row_nxt  = next_phase(raw_row_r, geom.vskip);
        raw_col_nxt  = '0;
        kept_col_nxt = '0;
      end
      if (in_frame_end) begin
        raw_row_nxt  = '0;
        kept_row_nxt = '0;
        row_base_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_col_r  <= '0;
      raw_row_r  <= '0;
      kept_col_r <= '0;
      kept_row_r <= '0;
      row_base_r <= '0;
    end else begin
      raw_col_r  <= raw_col_nxt;
      raw_row_r  <= raw_row_nxt;
      kept_col_r <= kept_col_nxt;
      kept_row_r <= kept_row_nxt;
      row_base_r <= row_base_nxt;
    end
  end

endmodule

// ----- sv/fdmd_queue.sv -----
// ----------------------------------------------------------------------------
// fdmd_queue
// Small register FIFO between front and back; head shown combinationally.
// ----------------------------------------------------------------------------
module fdmd_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = fdmd_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  import fdmd_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r,  count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = slots_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Pointer and fill tracking
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- sv/fdmd_back.sv -----
// ----------------------------------------------------------------------------
// fdmd_back
// Reference store, per-pixel change test, changed count and frame result.
// A request pops into stage 1 while its store read is issued; the next cycle
// compares and writes the pixel back; a frame end loads the result once it can.
// ----------------------------------------------------------------------------
module fdmd_back #(
  parameter int unsigned MAX_COLUMNS = fdmd_pkg::FDMD_MAX_COLUMNS,
  parameter int unsigned MAX_ROWS    = fdmd_pkg::FDMD_MAX_ROWS
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    head_valid,
  input  fdmd_pkg::fdmd_tag_t                     head_tag,
  input  logic [$clog2(MAX_COLUMNS*MAX_ROWS)-1:0] head_addr,
  input  logic [fdmd_pkg::PIX_W-1:0]              head_pixel,
  output logic                                    pop,
  input  fdmd_pkg::fdmd_test_t                    test,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic                                    out_motion,
  output logic                                    out_reference_only,
  output fdmd_pkg::fdmd_back_status_t             status
);

  import fdmd_pkg::*;

  localparam int unsigned DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned PW_W  = GAIN_W + PIX_W;
  localparam int unsigned RHS_W = PW_W + 1;

  // Stage 1
  logic             s1_valid_r;
  fdmd_tag_t        s1_tag_r;
  logic [AW-1:0]    s1_addr_r;
  logic [PIX_W-1:0] s1_pixel_r;
  logic             fwd_hit_r;
  logic [PIX_W-1:0] fwd_data_r;

  // Frame state
  logic               primed_r;
  logic [COUNT_W-1:0] count_r;
  logic               any_r;

  // Result register
  logic out_valid_r, out_valid_nxt;
  logic out_motion_r;
  logic out_ref_r;

  logic               s1_block;
  logic               s1_done;
  logic               rd_en;
  logic               wr_en;
  logic [PIX_W-1:0]   rd_data;
  logic [PIX_W-1:0]   old_pix;
  logic [PIX_W-1:0]   diff;
  logic [PW_W-1:0]    prod;
  logic [RHS_W-1:0]   lhs;
  logic [RHS_W-1:0]   rhs;
  logic               changed;
  logic               compared;
  logic [COUNT_W-1:0] count_cur;
  logic               any_cur;
  logic               motion;

  // Flow control: only a frame end waits for the result register
  assign s1_block = s1_valid_r && s1_tag_r.frame_end && out_valid_r && !out_ready;
  assign s1_done  = s1_valid_r && !s1_block;
  assign pop      = head_valid && (!s1_valid_r || s1_done);
  assign rd_en    = pop && head_tag.kept;
  assign wr_en    = s1_done && s1_tag_r.kept;

  fdmd_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_ref_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_addr_r),
    .wr_data (s1_pixel_r),
    .rd_en   (rd_en),
    .rd_addr (head_addr),
    .rd_data (rd_data)
  );

  // Old value, bypassing a write that landed in the read cycle
  assign old_pix = fwd_hit_r ? fwd_data_r : rd_data;

  // Change test: |new - old| * 256 > gain * old + offset * 256
  assign diff     = (s1_pixel_r > old_pix) ? (s1_pixel_r - old_pix) : (old_pix - s1_pixel_r);
  assign prod     = PW_W'(test.gain) * PW_W'(old_pix);
  assign lhs      = RHS_W'({diff, 8'h00});
  assign rhs      = RHS_W'(prod) + RHS_W'({test.offset, 8'h00});
  assign compared = s1_tag_r.kept && primed_r;
  assign changed  = compared && (lhs > rhs);

  // Saturating count including this pixel
  assign count_cur = (changed && (count_r != '1)) ? count_r + COUNT_W'(1) : count_r;
  assign any_cur   = any_r || compared;
  assign motion    = any_cur && (count_cur >= test.threshold);

  // Stage 1 register and bypass capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (pop) begin
      s1_valid_r <= 1'b1;
    end else if (s1_done) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_tag_r   <= head_tag;
      s1_addr_r  <= head_addr;
      s1_pixel_r <= head_pixel;
      fwd_hit_r  <= wr_en && (s1_addr_r == head_addr);
      fwd_data_r <= s1_pixel_r;
    end
  end

  // Frame state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r <= 1'b0;
      count_r  <= '0;
      any_r    <= 1'b0;
    end else if (s1_done) begin
      if (s1_tag_r.frame_end) begin
        primed_r <= 1'b1;
        count_r  <= '0;
        any_r    <= 1'b0;
      end else begin
        count_r  <= count_cur;
        any_r    <= any_cur;
      end
    end
  end

  // Result register
  assign out_valid_nxt = (out_valid_r && !out_ready) || (s1_done && s1_tag_r.frame_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_done && s1_tag_r.frame_end) begin
      out_motion_r <= primed_r && motion;
      out_ref_r    <= !primed_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_motion         = out_motion_r;
  assign out_reference_only = out_ref_r;

  assign status.s1_stalled = s1_block;
  assign status.ram_read   = rd_en;

endmodule

// ----- sv/frame_difference_motion_detect_core.sv -----
// Throughput: one pixel per clock; the reference store takes one read and one
//   write per cycle on separate ports, and a stall only arises when a result
//   waits on out_ready.
// Reset: control, counters and configuration registers return to their defaults; the
//   reference store is not cleared, the first frame after reset loads it.
// ----------------------------------------------------------------------------
// frame_difference_motion_detect_core
// Decimating frame-difference motion detector: front raster tracker, short
// queue, back change test against the reference store, one result per frame.
// ----------------------------------------------------------------------------
module frame_difference_motion_detect_core #(
  parameter int unsigned MAX_COLUMNS = fdmd_pkg::FDMD_MAX_COLUMNS,
  parameter int unsigned MAX_ROWS    = fdmd_pkg::FDMD_MAX_ROWS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [fdmd_pkg::PIX_W-1:0]          in_pixel,
  input  logic                                in_line_end,
  input  logic                                in_frame_end,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_motion,
  output logic                                out_reference_only,
  input  logic                                cfg_write_en,
  input  logic [fdmd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [fdmd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import fdmd_pkg::*;

  localparam int unsigned AW = $clog2(MAX_COLUMNS * MAX_ROWS);
  localparam int unsigned QW = $bits(fdmd_tag_t) + AW + PIX_W;

  fdmd_geom_t geom_r;
  fdmd_test_t test_r;

  fdmd_tag_t         q_tag;
  logic [AW-1:0]     q_addr;
  logic [PIX_W-1:0]  q_pixel;
  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              head_valid;
  logic [QW-1:0]     head_data;
  fdmd_tag_t         head_tag;
  logic [AW-1:0]     head_addr;
  logic [PIX_W-1:0]  head_pixel;
  fdmd_back_status_t back_status;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_r.hskip   <= RST_HSKIP;
      geom_r.vskip   <= RST_VSKIP;
      geom_r.cols    <= RST_COLUMNS;
      geom_r.rows    <= RST_ROWS;
      test_r.gain    <= RST_GAIN;
      test_r.offset  <= RST_OFFSET;
      test_r.threshold <= RST_THRESHOLD;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_HSKIP:     geom_r.hskip     <= cfg_data[SKIP_W-1:0];
        CFG_VSKIP:     geom_r.vskip     <= cfg_data[SKIP_W-1:0];
        CFG_COLUMNS:   geom_r.cols      <= cfg_data[COLS_W-1:0];
        CFG_ROWS:      geom_r.rows      <= cfg_data[ROWS_W-1:0];
        CFG_GAIN:      test_r.gain      <= cfg_data[GAIN_W-1:0];
        CFG_OFFSET:    test_r.offset    <= cfg_data[OFFS_W-1:0];
        CFG_THRESHOLD: test_r.threshold <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  fdmd_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_pixel     (in_pixel),
    .in_line_end  (in_line_end),
    .in_frame_end (in_frame_end),
    .geom         (geom_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_tag        (q_tag),
    .q_addr       (q_addr),
    .q_pixel      (q_pixel)
  );

  fdmd_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  ({q_tag, q_addr, q_pixel}),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  assign {head_tag, head_addr, head_pixel} = head_data;

  fdmd_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head_valid         (head_valid),
    .head_tag           (head_tag),
    .head_addr          (head_addr),
    .head_pixel         (head_pixel),
    .pop                (q_pop),
    .test               (test_r),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_motion         (out_motion),
    .out_reference_only (out_reference_only),
    .status             (back_status)
  );

  // Front never pushes into a full queue
  a_no_queue_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("push into full queue");

  // A priming frame never reports motion
  a_ref_only_no_motion: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_motion && out_reference_only))
    else $error("motion on reference-only frame");

  // No store read while stage 1 holds its read data
  a_no_read_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    back_status.s1_stalled |-> !back_status.ram_read)
    else $error("store read during stage 1 stall");

  // Queue only drains while the back side can take a request
  a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> head_valid && !back_status.s1_stalled)
    else $error("pop without head or during stall");

endmodule
